>>> hw/rtl/chunked_slot_allocator_core_defines.svh
// assertion macros for the slot allocator core
// used by the top level only
`ifndef CHUNKED_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define CHUNKED_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define CSA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/csa_pkg.sv
// shared types and constants of the slot allocator core
// no dependencies
`default_nettype none
package csa_pkg;
  localparam int NumChunks = 8;
  localparam int MaxSlots = 64;
  localparam int ChW = $clog2(NumChunks);
  localparam int SlW = $clog2(MaxSlots);
  localparam int CntW = $clog2(NumChunks + 1);
  localparam int FcW = $clog2(MaxSlots + 1);
  localparam int HW = ChW + SlW;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBadFree = 2'd2;
  localparam logic ActAlloc = 1'b0;
  localparam logic [1:0] RegCapacity = 2'd0;

  typedef struct packed {
    logic          action;
    logic [HW-1:0] handle;
  } in_word_t;

  typedef struct packed {
    logic [HW-1:0] slot;
    logic [1:0]    status;
    logic          chunk_added;
    logic          chunk_released;
  } out_word_t;
endpackage
`default_nettype wire

>>> hw/rtl/chunked_slot_allocator_core.sv
// slot allocator core: chunk list, per chunk free stacks and in-use bits
// for each word the sequencer walks the chunk order list one entry a
// cycle for the first-fit search or release unlink, with one stack
// memory read or write step. one word at a time, the next is taken
// once the result word has been accepted.
// reset and capacity writes clear the in-use bits with a pass over all 512
// entries of the in-use memory; no word is accepted meanwhile.
// free stacks use lazy fill: a stack entry below the chunk's low water mark
// has not moved since fill and reads as its own index.
`default_nettype none
`include "chunked_slot_allocator_core_defines.svh"
module chunked_slot_allocator_core
  import csa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int Total = NumChunks * MaxSlots;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_NEWCH, S_POP, S_POPRD, S_FRD, S_FCHK,
    S_PUSH, S_UNLINK, S_DONE
  } state_t;

  state_t state_r;
  logic [FcW-1:0] cap_r;
  logic [ChW-1:0] order_r [NumChunks];
  logic [CntW-1:0] count_r;
  logic [NumChunks-1:0] active_r;
  logic [FcW-1:0] fc_r [NumChunks];
  // low water: entries below it are untouched since the chunk was filled
  logic [FcW-1:0] hw_r [NumChunks];
  logic [SlW-1:0] stack_mem [Total];
  logic [SlW-1:0] stack_q;
  logic use_mem [Total];
  logic use_q;
  logic [HW:0] clr_r;
  logic [CntW-1:0] p_r;
  logic [ChW-1:0] c_r;
  logic [SlW-1:0] s_r;
  logic added_r;
  out_word_t res_r;
  logic ovalid_r;
  logic cfg_wr;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr == RegCapacity);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == RegCapacity) ? {{(32-FcW){1'b0}}, cap_r} : 32'd0;
  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data = res_r;

  logic [HW-1:0] addr;
  logic [FcW-1:0] fcm1;
  logic [FcW-1:0] fc_push;
  assign fcm1 = fc_r[c_r] - FcW'(1);
  assign addr = {c_r, SlW'(fcm1)};
  assign fc_push = (fc_r[c_r] < FcW'(MaxSlots)) ? fc_r[c_r] + FcW'(1) : fc_r[c_r];

  // lowest inactive chunk
  logic [ChW-1:0] newch;
  always_comb begin
    newch = '0;
    for (int i = NumChunks - 1; i >= 0; i--)
      if (!active_r[i]) newch = ChW'(i);
  end

  function automatic logic [SlW-1:0] stack_sel();
    // entry at index fc-1, below the low water mark it still holds its own index
    if (fcm1 < hw_r[c_r]) return SlW'(fcm1);
    return stack_q;
  endfunction

  // memory ports
  always_ff @(posedge clk) begin
    stack_q <= stack_mem[(state_r == S_PUSH) ? {c_r, s_r} : addr];
    use_q <= use_mem[{c_r, s_r}];
    if (state_r == S_CLEAR) use_mem[clr_r[HW-1:0]] <= 1'b0;
    else if (state_r == S_POPRD) use_mem[{c_r, stack_sel()}] <= 1'b1;
    else if (state_r == S_PUSH) use_mem[{c_r, s_r}] <= 1'b0;
    if (state_r == S_PUSH && fc_r[c_r] < FcW'(MaxSlots))
      stack_mem[{c_r, SlW'(fc_r[c_r])}] <= s_r;
  end

  logic [FcW-1:0] cap_w;
  always_comb begin
    cap_w = cfg_pwdata[FcW-1:0];
    if (cfg_pwdata[6:0] == 7'd0) cap_w = FcW'(1);
    else if (cfg_pwdata[6:0] > 7'(MaxSlots)) cap_w = FcW'(MaxSlots);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      ovalid_r <= 1'b0;
      count_r <= CntW'(1);
      active_r <= NumChunks'(1);
      for (int i = 0; i < NumChunks; i++) order_r[i] <= '0;
      for (int i = 1; i < NumChunks; i++) begin
        fc_r[i] <= '0;
        hw_r[i] <= '0;
      end
      if (!rst_n) begin
        cap_r <= FcW'(MaxSlots);
        fc_r[0] <= FcW'(MaxSlots);
        hw_r[0] <= FcW'(MaxSlots);
      end else begin
        cap_r <= cap_w;
        fc_r[0] <= cap_w;
        hw_r[0] <= cap_w;
      end
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + (HW+1)'(1);
          if (clr_r == (HW+1)'(Total - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          added_r <= 1'b0;
          p_r <= '0;
          c_r <= in_data.handle[HW-1:SlW];
          s_r <= in_data.handle[SlW-1:0];
          state_r <= (in_data.action == ActAlloc) ? S_SEARCH : S_FRD;
        end
        S_SEARCH: begin
          if (p_r < count_r) begin
            c_r <= order_r[p_r[ChW-1:0]];
            if (fc_r[order_r[p_r[ChW-1:0]]] != '0) state_r <= S_POP;
            else p_r <= p_r + CntW'(1);
          end else if (count_r >= CntW'(NumChunks)) begin
            res_r <= '{slot: '0, status: StFull, chunk_added: 1'b0, chunk_released: 1'b0};
            state_r <= S_DONE;
          end else state_r <= S_NEWCH;
        end
        S_NEWCH: begin
          // lowest inactive chunk goes to the head, list shifts down by one
          for (int i = 1; i < NumChunks; i++) order_r[i] <= order_r[i-1];
          order_r[0] <= newch;
          count_r <= count_r + CntW'(1);
          added_r <= 1'b1;
          p_r <= '0;
          active_r[newch] <= 1'b1;
          fc_r[newch] <= cap_r;
          hw_r[newch] <= cap_r;
          state_r <= S_SEARCH;
        end
        S_POP: state_r <= S_POPRD;
        S_POPRD: begin
          res_r <= '{slot: {c_r, stack_sel()}, status: StOk,
                     chunk_added: added_r, chunk_released: 1'b0};
          fc_r[c_r] <= fcm1;
          if (fcm1 < hw_r[c_r]) hw_r[c_r] <= fcm1;
          state_r <= S_DONE;
        end
        S_FRD: state_r <= S_FCHK;
        S_FCHK: begin
          if (!active_r[c_r] || FcW'(s_r) >= cap_r || !use_q) begin
            res_r <= '{slot: '0, status: StBadFree, chunk_added: 1'b0, chunk_released: 1'b0};
            state_r <= S_DONE;
          end else state_r <= S_PUSH;
        end
        S_PUSH: begin
          p_r <= '0;
          res_r <= '{slot: '0, status: StOk, chunk_added: 1'b0, chunk_released: 1'b0};
          fc_r[c_r] <= fc_push;
          state_r <= (fc_push >= cap_r && count_r > CntW'(1)) ? S_UNLINK : S_DONE;
        end
        S_UNLINK: begin
          // find c, then close the gap one entry a cycle
          if (p_r + CntW'(1) < count_r) begin
            if (order_r[p_r[ChW-1:0]] == c_r || added_r) begin
              added_r <= 1'b1;
              order_r[p_r[ChW-1:0]] <= order_r[p_r[ChW-1:0] + ChW'(1)];
            end
            p_r <= p_r + CntW'(1);
          end else begin
            count_r <= count_r - CntW'(1);
            order_r[p_r[ChW-1:0]] <= '0;
            active_r[c_r] <= 1'b0;
            fc_r[c_r] <= '0;
            res_r.chunk_released <= 1'b1;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CSA_ASSERT_IMPL(a_busy_not_ready, state_r != S_IDLE, !in_ready, "ready while busy")
  `CSA_ASSERT_NEXT(a_done_valid, state_r == S_DONE && !cfg_wr, out_valid, "result lost")
  `CSA_ASSERT_IMPL(a_count_range, state_r == S_IDLE,
    count_r != '0 && count_r <= CntW'(NumChunks), "active count out of range")
endmodule
`default_nettype wire
